// ===== rtl/block_partitioned_prefix_sum_top_assert.svh =====
// Assertion macros for the blocked prefix sum block.
// Used by block_partitioned_prefix_sum_top; needs a clock and reset in scope.
`ifndef BLOCK_PARTITIONED_PREFIX_SUM_TOP_ASSERT_SVH
`define BLOCK_PARTITIONED_PREFIX_SUM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BPPS_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("bpps assertion failed");
`define BPPS_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("bpps assertion failed");
`else
`define BPPS_ASSERT_SAME(label, cond, prop)
`define BPPS_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ===== rtl/bpps_pkg.sv =====
// Shared widths, register codes and result payload type for the
// blocked prefix sum block. No dependencies.
package bpps_pkg;

   localparam int DATA_W       = 32;
   localparam int TOTAL_W      = 21;
   localparam int PE_W         = 13;
   localparam int SEG_W        = 12;
   localparam int MAX_SEGMENTS = 4096;
   localparam int MAX_ITEMS    = 1048576;
   localparam int DIV_CNT_W    = $clog2(TOTAL_W + 1);

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 21;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PE_COUNT    = 1'd1;

   typedef struct packed {
      logic signed [DATA_W-1:0] global_sum;
      logic signed [DATA_W-1:0] local_sum;
      logic [SEG_W-1:0]         segment_index;
      logic                     segment_last;
      logic                     stream_last;
      logic                     overflow;
   } rsp_payload_type;

endpackage

// ===== rtl/bpps_if.sv =====
// Request and response channel interfaces (valid/ready) for the
// blocked prefix sum block. Depends on bpps_pkg.
interface bpps_req_if;
   import bpps_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface bpps_rsp_if;
   import bpps_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] global_sum;
   logic signed [DATA_W-1:0] local_sum;
   logic [SEG_W-1:0]         segment_index;
   logic                     segment_last;
   logic                     stream_last;
   logic                     overflow;
   modport source (output valid, output global_sum, output local_sum,
                   output segment_index, output segment_last,
                   output stream_last, output overflow, input ready);
   modport sink (input valid, input global_sum, input local_sum,
                 input segment_index, input segment_last,
                 input stream_last, input overflow, output ready);
endinterface

// ===== rtl/block_partitioned_prefix_sum_top.sv =====
// A request's result is registered into the response register, or into the second entry
// while that is full. Throughput: one request per cycle while the divider is idle
// and the second entry is empty; the two-entry output stage keeps accepting while
// a result waits. A register write starts a restoring size division and stalls requests.
// Reset (synchronous): total_count 0, segment count 1, sizes valid at once, run cleared.
// Depends on bpps_pkg, bpps_if.sv and block_partitioned_prefix_sum_top_assert.svh.
module block_partitioned_prefix_sum_top (
   input  logic                              clock,
   input  logic                              reset,
   bpps_req_if.sink                          req,
   bpps_rsp_if.source                        rsp,
   input  logic                              csr_write_enable,
   input  logic [bpps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bpps_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bpps_pkg::*;

   // configuration and derived sizes
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [PE_W-1:0]      pe_ff, pe_in;
   logic [TOTAL_W-1:0]   eff_total_ff, eff_total_in;
   logic [PE_W-1:0]      divisor_ff, divisor_in;
   logic [TOTAL_W-1:0]   base_ff, base_in;
   logic [SEG_W-1:0]     long_ff, long_in;

   // divider
   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]   quo_ff, quo_in;
   logic [SEG_W-1:0]     rem_ff, rem_in;

   // run state
   logic [TOTAL_W-1:0]   items_ff, items_in;
   logic [TOTAL_W-1:0]   pos_ff, pos_in;
   logic [SEG_W-1:0]     cur_ff, cur_in;
   logic [DATA_W-1:0]    local_ff, local_in;
   logic [DATA_W-1:0]    carry_ff, carry_in;
   logic                 ov_ff, ov_in;

   // output stage
   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_payload_type      out_ff, out_in;
   rsp_payload_type      skid_ff, skid_in;

   // combinational terms
   logic [TOTAL_W-1:0]   tot_raw;
   logic [PE_W-1:0]      pe_raw;
   logic [PE_W:0]        rem_shift;
   logic                 quo_bit;
   logic [PE_W:0]        rem_diff;
   logic [TOTAL_W:0]     seg_len;
   logic [TOTAL_W:0]     pos_next;
   logic [TOTAL_W:0]     items_next;
   logic [DATA_W-1:0]    value_u;
   logic [DATA_W-1:0]    local_sum;
   logic [DATA_W-1:0]    global_sum;
   logic                 ov_local;
   logic                 ov_global;
   logic                 seg_last;
   logic                 str_last;
   logic                 accept;
   logic                 push;
   logic                 pop;
   rsp_payload_type      result;

   assign req.ready = !busy_ff && !skid_valid_ff;
   assign accept    = req.valid && req.ready;
   assign push      = accept && (eff_total_ff != '0);
   assign pop       = out_valid_ff && rsp.ready;

   // one restoring division step
   assign rem_shift = {1'b0, rem_ff, quo_ff[TOTAL_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign quo_bit   = (rem_shift >= {1'b0, divisor_ff});

   // per-request datapath
   assign value_u    = req.value;
   assign local_sum  = local_ff + value_u;
   assign global_sum = carry_ff + local_sum;
   assign ov_local   = (local_ff[DATA_W-1] ^ local_sum[DATA_W-1]) &
                       (value_u[DATA_W-1] ^ local_sum[DATA_W-1]);
   assign ov_global  = (carry_ff[DATA_W-1] ^ global_sum[DATA_W-1]) &
                       (local_sum[DATA_W-1] ^ global_sum[DATA_W-1]);
   assign seg_len    = {1'b0, base_ff} + {{TOTAL_W{1'b0}}, (cur_ff < long_ff)};
   assign pos_next   = {1'b0, pos_ff} + {{TOTAL_W{1'b0}}, 1'b1};
   assign items_next = {1'b0, items_ff} + {{TOTAL_W{1'b0}}, 1'b1};
   assign seg_last   = (pos_next >= seg_len);
   assign str_last   = (items_next >= {1'b0, eff_total_ff});

   always_comb begin
      result.global_sum    = global_sum;
      result.local_sum     = local_sum;
      result.segment_index = cur_ff;
      result.segment_last  = seg_last;
      result.stream_last   = str_last;
      result.overflow      = ov_ff | ov_local | ov_global;
   end

   always_comb begin
      total_in      = total_ff;
      pe_in         = pe_ff;
      eff_total_in  = eff_total_ff;
      divisor_in    = divisor_ff;
      base_in       = base_ff;
      long_in       = long_ff;
      busy_in       = busy_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      items_in      = items_ff;
      pos_in        = pos_ff;
      cur_in        = cur_ff;
      local_in      = local_ff;
      carry_in      = carry_ff;
      ov_in         = ov_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      tot_raw       = total_ff;
      pe_raw        = pe_ff;

      // advance the divider; the last step lands quotient and remainder
      if (busy_ff) begin
         quo_in = {quo_ff[TOTAL_W-2:0], quo_bit};
         rem_in = quo_bit ? rem_diff[SEG_W-1:0] : rem_shift[SEG_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            base_in = {quo_ff[TOTAL_W-2:0], quo_bit};
            long_in = quo_bit ? rem_diff[SEG_W-1:0] : rem_shift[SEG_W-1:0];
         end
      end

      // run state update for an accepted request while the sequence length is nonzero
      if (push) begin
         ov_in = ov_ff | ov_local | ov_global;
         if (str_last) begin
            items_in = '0;
            pos_in   = '0;
            cur_in   = '0;
            local_in = '0;
            carry_in = '0;
            ov_in    = 1'b0;
         end else if (seg_last) begin
            items_in = items_next[TOTAL_W-1:0];
            pos_in   = '0;
            cur_in   = cur_ff + SEG_W'(1);
            local_in = '0;
            carry_in = global_sum;
         end else begin
            items_in = items_next[TOTAL_W-1:0];
            pos_in   = pos_next[TOTAL_W-1:0];
            local_in = local_sum;
         end
      end

      // two-entry output stage
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end

      // register write: restart the run, clear the output stage and recompute segment sizes
      if (csr_write_enable) begin
         if (csr_index == CSR_TOTAL_COUNT) begin
            tot_raw = csr_write_data[TOTAL_W-1:0];
         end else begin
            pe_raw = csr_write_data[PE_W-1:0];
         end
         total_in = tot_raw;
         pe_in    = pe_raw;
         eff_total_in = (tot_raw > TOTAL_W'(MAX_ITEMS)) ? TOTAL_W'(MAX_ITEMS) : tot_raw;
         if (pe_raw == '0) begin
            divisor_in = PE_W'(1);
         end else if (pe_raw > PE_W'(MAX_SEGMENTS)) begin
            divisor_in = PE_W'(MAX_SEGMENTS);
         end else begin
            divisor_in = pe_raw;
         end
         busy_in       = 1'b1;
         cnt_in        = DIV_CNT_W'(TOTAL_W);
         quo_in        = eff_total_in;
         rem_in        = '0;
         items_in      = '0;
         pos_in        = '0;
         cur_in        = '0;
         local_in      = '0;
         carry_in      = '0;
         ov_in         = 1'b0;
         out_valid_in  = 1'b0;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         pe_ff         <= PE_W'(1);
         eff_total_ff  <= '0;
         divisor_ff    <= PE_W'(1);
         base_ff       <= '0;
         long_ff       <= '0;
         busy_ff       <= 1'b0;
         cnt_ff        <= '0;
         quo_ff        <= '0;
         rem_ff        <= '0;
         items_ff      <= '0;
         pos_ff        <= '0;
         cur_ff        <= '0;
         local_ff      <= '0;
         carry_ff      <= '0;
         ov_ff         <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         total_ff      <= total_in;
         pe_ff         <= pe_in;
         eff_total_ff  <= eff_total_in;
         divisor_ff    <= divisor_in;
         base_ff       <= base_in;
         long_ff       <= long_in;
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         quo_ff        <= quo_in;
         rem_ff        <= rem_in;
         items_ff      <= items_in;
         pos_ff        <= pos_in;
         cur_ff        <= cur_in;
         local_ff      <= local_in;
         carry_ff      <= carry_in;
         ov_ff         <= ov_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.global_sum    = out_ff.global_sum;
   assign rsp.local_sum     = out_ff.local_sum;
   assign rsp.segment_index = out_ff.segment_index;
   assign rsp.segment_last  = out_ff.segment_last;
   assign rsp.stream_last   = out_ff.stream_last;
   assign rsp.overflow      = out_ff.overflow;

`include "block_partitioned_prefix_sum_top_assert.svh"

   `BPPS_ASSERT_SAME(a_busy_blocks_req, busy_ff, !req.ready)
   `BPPS_ASSERT_SAME(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   `BPPS_ASSERT_NEXT(a_write_starts_div, csr_write_enable, busy_ff && !out_valid_ff)
   `BPPS_ASSERT_SAME(a_stream_ends_seg, rsp.valid && rsp.stream_last, rsp.segment_last)

endmodule

// ===== dv/bpps_prefix_checker.sv =====
// Checker for the blocked prefix sum block: watches the request, response and
// register ports, predicts every response and compares field by field.
// Depends on bpps_pkg and the channel interfaces in bpps_if.sv.
module bpps_prefix_checker (
   input  logic                             clock,
   input  logic                             reset,
   bpps_req_if                              req,
   bpps_rsp_if                              rsp,
   input  logic                             csr_write_enable,
   input  logic [bpps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpps_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                               mismatch_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpps_pkg::*;

   localparam int FIELD_W = DATA_W + 1;

   logic [TOTAL_W-1:0] total_setting;
   logic [PE_W-1:0]    pe_setting;

   int unsigned        scan_length;
   int unsigned        short_length;
   int unsigned        long_count;
   int unsigned        scanned;
   int unsigned        seg_offset;
   logic [SEG_W-1:0]   seg_now;
   logic [DATA_W-1:0]  seg_sum;
   logic [DATA_W-1:0]  carry_sum;
   bit                 sum_overflow;

   rsp_payload_type    expected_sums[$];
   int                 errors = 0;

   function automatic void size_segments();
      int unsigned pe;
      int unsigned tot;
      pe  = 32'(pe_setting);
      tot = 32'(total_setting);
      if (pe == 0) pe = 1;
      if (pe > MAX_SEGMENTS) pe = MAX_SEGMENTS;
      if (tot > MAX_ITEMS) tot = MAX_ITEMS;
      scan_length  = tot;
      short_length = tot / pe;
      long_count   = tot % pe;
   endfunction

   function automatic void restart_scan();
      scanned      = 0;
      seg_offset   = 0;
      seg_now      = '0;
      seg_sum      = '0;
      carry_sum    = '0;
      sum_overflow = 1'b0;
   endfunction

   // wrap in two's complement, flag a sign flip on like-signed operands
   function automatic logic [DATA_W-1:0] add_checked(input logic [DATA_W-1:0] a,
                                                     input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] s;
      s = a + b;
      if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
         sum_overflow = 1'b1;
      return s;
   endfunction

   function automatic void predict_prefix(input logic [DATA_W-1:0] v);
      int unsigned       seg_len;
      logic [DATA_W-1:0] global_now;
      rsp_payload_type   sums;
      if (scan_length == 0) return;
      seg_len = short_length + ((seg_now < long_count) ? 1 : 0);
      seg_sum = add_checked(seg_sum, v);
      global_now = add_checked(carry_sum, seg_sum);
      seg_offset++;
      scanned++;
      sums.global_sum    = global_now;
      sums.local_sum     = seg_sum;
      sums.segment_index = seg_now;
      sums.segment_last  = (seg_offset >= seg_len);
      sums.stream_last   = (scanned >= scan_length);
      sums.overflow      = sum_overflow;
      expected_sums = {expected_sums, sums};
      if (sums.segment_last) begin
         carry_sum  = global_now;
         seg_sum    = '0;
         seg_offset = 0;
         seg_now    = seg_now + SEG_W'(1);
      end
      if (sums.stream_last) restart_scan();
   endfunction

   function automatic void check_field(input string field,
                                       input logic signed [FIELD_W-1:0] want,
                                       input logic signed [FIELD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   function automatic void compare_sums();
      rsp_payload_type want;
      if (expected_sums.size() == 0) begin
         $display("%0t: response with no request pending: expected none, actual global_sum %0d",
                  $time, rsp.global_sum);
         errors++;
         return;
      end
      want = expected_sums.pop_front();
      check_field("global_sum", FIELD_W'(want.global_sum), FIELD_W'(rsp.global_sum));
      check_field("local_sum", FIELD_W'(want.local_sum), FIELD_W'(rsp.local_sum));
      check_field("segment_index", FIELD_W'(want.segment_index),
                  FIELD_W'(rsp.segment_index));
      check_field("segment_last", FIELD_W'(want.segment_last), FIELD_W'(rsp.segment_last));
      check_field("stream_last", FIELD_W'(want.stream_last), FIELD_W'(rsp.stream_last));
      check_field("overflow", FIELD_W'(want.overflow), FIELD_W'(rsp.overflow));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         total_setting = '0;
         pe_setting    = PE_W'(1);
         size_segments();
         restart_scan();
         expected_sums.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_TOTAL_COUNT)
               total_setting = csr_write_data[TOTAL_W-1:0];
            else if (csr_index == CSR_PE_COUNT)
               pe_setting = csr_write_data[PE_W-1:0];
            size_segments();
            restart_scan();
         end
         if (req.valid && req.ready) predict_prefix(req.value);
         if (rsp.valid && rsp.ready) compare_sums();
      end
      mismatch_count <= errors;
      pending_count  <= expected_sums.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Top of the blocked prefix sum testbench: clock, reset, register writes and
// request/response traffic with random idling; the checker gives the verdict input.
// Depends on bpps_pkg, bpps_if.sv, the block and bpps_prefix_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bpps_pkg::*;

   typedef enum {VALUES_SMALL, VALUES_MIXED, VALUES_WIDE} value_mode_type;

   localparam logic [DATA_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam int RANDOM_ITEMS  = 1320;
   localparam int SETTLE_CYCLES = 24;
   localparam int LATENCY_SLACK = 4;
   localparam int HOLD_CYCLES   = 48;
   localparam int IDLE_LIMIT    = 5000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     mismatch_count;
   int                     pending_count;

   bit                     burst_mode = 1'b0;
   bit                     drain_hold = 1'b0;
   int unsigned            cur_total  = 0;
   int unsigned            sent_items = 0;

   bpps_req_if req_bus ();
   bpps_rsp_if rsp_bus ();

   block_partitioned_prefix_sum_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   bpps_prefix_checker prefix_check (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [DATA_W-1:0] draw_value(input value_mode_type mode);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (mode == VALUES_WIDE || (mode == VALUES_MIXED && pick < 20)) return $urandom();
      if (mode == VALUES_MIXED && pick < 30) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return '1;
            default: return '0;
         endcase
      end
      return $urandom_range(0, 2000) - 1000;
   endfunction

   task automatic send_value(input logic [DATA_W-1:0] v);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drop valid and wait for every outstanding response
   task automatic settle_idle();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_count != 0 && waited < IDLE_LIMIT);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   // each write restarts the size division; let it finish before the next one
   task automatic configure(input bit set_total, input bit set_pe,
                            input int unsigned total, input int unsigned pe_word);
      if (set_total) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_TOTAL_COUNT;
         csr_write_data   <= total[CSR_DATA_W-1:0];
         cur_total         = total[TOTAL_W-1:0];
         @(posedge clock);
         csr_write_enable <= 1'b0;
      end
      if (set_pe) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_PE_COUNT;
         csr_write_data   <= pe_word[CSR_DATA_W-1:0];
         @(posedge clock);
         csr_write_enable <= 1'b0;
      end
   endtask

   initial begin : rsp_drain
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         gap = burst_mode ? 0 : $urandom_range(0, 7);
         if (drain_hold) begin
            gap = HOLD_CYCLES;
            drain_hold = 1'b0;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      int unsigned total;
      int unsigned pe_word;
      int unsigned count;
      int unsigned pick;
      int unsigned scan;
      bit          set_total;
      bit          set_pe;
      value_mode_type mode;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.value    <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_TOTAL_COUNT;
      csr_write_data   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty sequence after reset: requests are dropped
      send_value(VALUE_MAX);
      send_value(VALUE_MIN);
      settle_idle();

      // one long segment and one short, overflow in both sums, then a second pass
      configure(1'b1, 1'b1, 5, 2);
      send_value(VALUE_MAX);
      send_value(1);
      send_value('1);
      send_value(VALUE_MIN);
      send_value(0);
      send_value(3);
      send_value(-3);
      send_value(100);
      send_value(VALUE_MIN);
      send_value('1);
      settle_idle();

      // zero segments act as one; stop part way, the next write restarts
      configure(1'b0, 1'b1, 0, 0);
      send_value(7);
      send_value(-9);
      send_value(VALUE_MAX);
      settle_idle();

      // more segments than items leaves empty segments
      configure(1'b1, 1'b1, 3, 8);
      send_value(11);
      send_value(-22);
      send_value(33);
      settle_idle();

      // segment count above the maximum is clamped
      configure(1'b1, 1'b1, 4097, 8191);
      send_value(1);
      send_value(2);
      send_value(4);
      settle_idle();

      configure(1'b1, 1'b1, MAX_ITEMS, MAX_SEGMENTS - 1);
      send_value(VALUE_MIN);
      send_value(-1);
      send_value(5);
      settle_idle();

      configure(1'b1, 1'b1, 1, 1);
      send_value(VALUE_MAX);
      send_value(VALUE_MAX);
      send_value(-77);
      settle_idle();

      // oversized count is clamped, first segment ends after 256; full back-pressure
      configure(1'b1, 1'b1, {CSR_DATA_W{1'b1}}, MAX_SEGMENTS);
      burst_mode = 1'b1;
      drain_hold = 1'b1;
      repeat (260) send_value(draw_value(VALUES_SMALL));
      burst_mode = 1'b0;
      sent_items += 260;

      while (sent_items < RANDOM_ITEMS) begin
         settle_idle();
         pick = $urandom_range(0, 9);
         // always replace a long sequence length left from the stress pass
         set_total = (pick != 0 && pick != 2) || (cur_total > 200);
         set_pe    = (pick != 0 && pick != 1);

         pick = $urandom_range(0, 99);
         if (pick < 5) total = 0;
         else if (pick < 15) total = 1;
         else if (pick < 25) total = $urandom_range(41, 200);
         else total = $urandom_range(2, 40);

         pick = $urandom_range(0, 99);
         if (pick < 8) pe_word = 0;
         else if (pick < 14) pe_word = $urandom_range(MAX_SEGMENTS, 8191);
         else if (pick < 24) pe_word = 1;
         else pe_word = $urandom_range(1, total + 4);
         // upper bits of the write word are not part of the segment count
         if ($urandom_range(0, 7) == 0) pe_word |= $urandom_range(1, 255) << PE_W;

         configure(set_total, set_pe, total, pe_word);

         scan = (cur_total > MAX_ITEMS) ? MAX_ITEMS : cur_total;
         if (scan == 0) begin
            count = $urandom_range(1, 4);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) count = scan * ((scan > 40) ? 1 : $urandom_range(1, 3));
            else if (pick < 9) count = $urandom_range(1, scan);
            else count = scan + $urandom_range(1, scan);
            sent_items += count;
         end

         pick = $urandom_range(0, 3);
         if (pick == 0) mode = VALUES_SMALL;
         else if (pick == 1) mode = VALUES_WIDE;
         else mode = VALUES_MIXED;

         burst_mode = ($urandom_range(0, 4) == 0);
         if (count >= 20 && $urandom_range(0, 9) == 0) begin
            burst_mode = 1'b1;
            drain_hold = 1'b1;
         end
         repeat (count) send_value(draw_value(mode));
         burst_mode = 1'b0;
      end

      settle_idle();
      if (pending_count != 0)
         $display("%0t: expected %0d more responses, actual none", $time, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
